### rtl/core/drbt_pkg.sv
// ----------------------------------------------------------------------------
// drbt_pkg: shared definitions for the DRAM row buffer timing core
// Sizes, codes and the queue entry type shared by the front part, the queue,
// the back part and the top level.
// ----------------------------------------------------------------------------
package drbt_pkg;

   // Store geometry.
   localparam int ROW_COUNT    = 1024;
   localparam int COLUMN_COUNT = 256;
   localparam int STORE_WORDS  = ROW_COUNT * COLUMN_COUNT;
   localparam int ROW_BITS     = $clog2(ROW_COUNT);
   localparam int COL_BITS     = $clog2(COLUMN_COUNT);
   localparam int SLOT_BITS    = $clog2(STORE_WORDS);

   // Field widths.
   localparam int ADDR_BITS  = 18;
   localparam int DATA_BITS  = 32;
   localparam int TIME_BITS  = 32;
   localparam int DELAY_BITS = 10;
   // Worst case cost is two row delays plus one column delay.
   localparam int COST_BITS  = DELAY_BITS + 2;

   // Queue between the front and the back part.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Register port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_ROW_DELAY    = 1'b0;
   localparam logic CSR_COLUMN_DELAY = 1'b1;
   localparam logic [DELAY_BITS-1:0] ROW_DELAY_RESET    = DELAY_BITS'(10);
   localparam logic [DELAY_BITS-1:0] COLUMN_DELAY_RESET = DELAY_BITS'(2);

   // Request kinds.
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef enum logic [1:0] {
      EVENT_HIT       = 2'd0,
      EVENT_ACTIVATE  = 2'd1,
      EVENT_WRITEBACK = 2'd2
   } row_event_type;

   // One classified request waiting for the back part.
   typedef struct packed {
      logic                 is_write;
      logic [SLOT_BITS-1:0] slot;
      logic [DATA_BITS-1:0] wdata;
      logic [TIME_BITS-1:0] issue;
      row_event_type        row_event;
      logic [COST_BITS-1:0] cost;
   } entry_type;

   // Status the back part reports to the front part and the top level.
   typedef struct packed {
      logic                 clear_busy;
      logic [TIME_BITS-1:0] busy_until;
   } back_status_type;

endpackage

### rtl/core/drbt_front.sv
// ----------------------------------------------------------------------------
// drbt_front: request intake and row classification
// Tracks the open row, decides the row event and the cost of each request,
// and hands the classified request to the queue.
// ----------------------------------------------------------------------------
module drbt_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [drbt_pkg::ADDR_BITS-1:0]       req_word_addr,
   input  logic signed [drbt_pkg::DATA_BITS-1:0] req_write_data,
   input  logic [drbt_pkg::TIME_BITS-1:0]       req_issue_time,
   input  logic [drbt_pkg::DELAY_BITS-1:0]      row_delay,
   input  logic [drbt_pkg::DELAY_BITS-1:0]      column_delay,
   input  drbt_pkg::back_status_type            status,
   input  logic                                 queue_full,
   output logic                                 push_valid,
   output drbt_pkg::entry_type                  push_entry
);

   logic                             row_valid_ff, row_valid_in;
   logic [drbt_pkg::ROW_BITS-1:0]    open_row_ff, open_row_in;
   logic [drbt_pkg::ROW_BITS-1:0]    row;
   logic [drbt_pkg::COL_BITS-1:0]    col;
   logic                             hit;
   drbt_pkg::row_event_type          row_event;
   logic [drbt_pkg::COST_BITS-1:0]   cost;

   assign req_ready  = !queue_full && !status.clear_busy;
   assign push_valid = req_valid && req_ready;

   always_comb begin
      // Both counts are powers of two: the column is the low address bits and
      // the row the bits above it, taken modulo the row count.
      row      = req_word_addr[drbt_pkg::COL_BITS +: drbt_pkg::ROW_BITS];
      col      = req_word_addr[drbt_pkg::COL_BITS-1:0];
      hit      = row_valid_ff && (open_row_ff == row);
      if (hit) begin
         row_event = drbt_pkg::EVENT_HIT;
         cost      = drbt_pkg::COST_BITS'(column_delay);
      end else if (row_valid_ff) begin
         // Write back the open row, even when clean, then activate.
         row_event = drbt_pkg::EVENT_WRITEBACK;
         cost      = drbt_pkg::COST_BITS'(row_delay) + drbt_pkg::COST_BITS'(row_delay)
                     + drbt_pkg::COST_BITS'(column_delay);
      end else begin
         row_event = drbt_pkg::EVENT_ACTIVATE;
         cost      = drbt_pkg::COST_BITS'(row_delay) + drbt_pkg::COST_BITS'(column_delay);
      end
   end

   always_comb begin
      push_entry.is_write  = (req_type == drbt_pkg::REQ_WRITE);
      push_entry.slot      = {row, col};
      push_entry.wdata     = req_write_data;
      push_entry.issue     = req_issue_time;
      push_entry.row_event = row_event;
      push_entry.cost      = cost;
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      open_row_in  = open_row_ff;
      if (push_valid && !hit) begin
         row_valid_in = 1'b1;
         open_row_in  = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         open_row_ff  <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
         open_row_ff  <= open_row_in;
      end
   end

endmodule

### rtl/core/drbt_queue.sv
// ----------------------------------------------------------------------------
// drbt_queue: short queue between the front and the back part
// A small first-in first-out buffer of classified requests.
// ----------------------------------------------------------------------------
module drbt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  drbt_pkg::entry_type push_entry,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_ready,
   output drbt_pkg::entry_type pop_entry
);

   drbt_pkg::entry_type                slots_ff [drbt_pkg::QUEUE_DEPTH];
   logic [drbt_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [drbt_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [drbt_pkg::QCNT_BITS-1:0]     count_ff, count_in;
   logic                               do_pop;

   assign full      = (count_ff == drbt_pkg::QCNT_BITS'(drbt_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == drbt_pkg::QPTR_BITS'(drbt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == drbt_pkg::QPTR_BITS'(drbt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/drbt_back.sv
// ----------------------------------------------------------------------------
// drbt_back: bank service, data store and result register
// Runs the clearing pass after reset, serves the store access of each
// request, keeps the busy-until time and holds the result for the receiver.
// ----------------------------------------------------------------------------
module drbt_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  drbt_pkg::entry_type                   pop_entry,
   output drbt_pkg::back_status_type             status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [drbt_pkg::DATA_BITS-1:0] rsp_read_data,
   output logic [drbt_pkg::TIME_BITS-1:0]        rsp_start_time,
   output logic [drbt_pkg::TIME_BITS-1:0]        rsp_finish_time,
   output logic [1:0]                            rsp_row_event
);

   logic [drbt_pkg::DATA_BITS-1:0] mem [drbt_pkg::STORE_WORDS];

   logic                            clear_busy_ff, clear_busy_in;
   logic [drbt_pkg::SLOT_BITS-1:0]  clear_addr_ff, clear_addr_in;
   logic [drbt_pkg::TIME_BITS-1:0]  busy_until_ff, busy_until_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [drbt_pkg::DATA_BITS-1:0]  rdata_ff;
   logic                            is_write_ff;
   logic [drbt_pkg::TIME_BITS-1:0]  start_ff;
   logic [drbt_pkg::TIME_BITS-1:0]  finish_ff;
   drbt_pkg::row_event_type         row_event_ff;
   logic [drbt_pkg::TIME_BITS-1:0]  start;
   logic [drbt_pkg::TIME_BITS-1:0]  finish;
   logic                            take;

   assign pop_ready = !clear_busy_ff && (!rsp_valid_ff || rsp_ready);
   assign take      = pop_valid && pop_ready;

   assign start  = (pop_entry.issue > busy_until_ff) ? pop_entry.issue : busy_until_ff;
   assign finish = start + drbt_pkg::TIME_BITS'(pop_entry.cost);

   assign status.clear_busy = clear_busy_ff;
   assign status.busy_until = busy_until_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = is_write_ff ? '0 : rdata_ff;
   assign rsp_start_time  = start_ff;
   assign rsp_finish_time = finish_ff;
   assign rsp_row_event   = row_event_ff;

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == drbt_pkg::SLOT_BITS'(drbt_pkg::STORE_WORDS - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
      busy_until_in = take ? finish : busy_until_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         busy_until_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         busy_until_ff <= busy_until_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Data store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (take && pop_entry.is_write) begin
         mem[pop_entry.slot] <= pop_entry.wdata;
      end
      if (take) begin
         rdata_ff <= mem[pop_entry.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         is_write_ff  <= pop_entry.is_write;
         start_ff     <= start;
         finish_ff    <= finish;
         row_event_ff <= pop_entry.row_event;
      end
   end

endmodule

### rtl/core/dram_row_buffer_timing_core.sv
// ----------------------------------------------------------------------------
// dram_row_buffer_timing_core: single-bank open-page DRAM timing core
// Each word on the request channel is a read or write of one data word.
// The core works out when the bank starts and finishes it, which row event
// it caused, and returns the word read.
//
// Use: requests enter on req_valid/req_ready and results leave on
// rsp_valid/rsp_ready, one result word per request, in request order.
// An accepted request is written into the queue, is taken from there by the
// back part, and has its result presented from the result register. While
// the receiver takes results, a new request can be accepted in every cycle;
// the sustained rate is one request per cycle, set by the back part, which
// takes one request from the queue per cycle.
// After reset the data store is cleared one word per cycle, a pass over all
// ROW_COUNT * COLUMN_COUNT words; req_ready stays low meanwhile,
// while register writes are taken as usual. When the receiver stalls, the
// result register holds its word, the two-entry queue fills, and then
// req_ready drops until the receiver takes a word.
// Registers row_delay (address 0) and column_delay (address 4) are to be
// written only while no request is in flight.
// ----------------------------------------------------------------------------
module dram_row_buffer_timing_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // Register port.
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [drbt_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [drbt_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [drbt_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                   pready,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [drbt_pkg::ADDR_BITS-1:0]         req_word_addr,
   input  logic signed [drbt_pkg::DATA_BITS-1:0]  req_write_data,
   input  logic [drbt_pkg::TIME_BITS-1:0]         req_issue_time,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [drbt_pkg::DATA_BITS-1:0]  rsp_read_data,
   output logic [drbt_pkg::TIME_BITS-1:0]         rsp_start_time,
   output logic [drbt_pkg::TIME_BITS-1:0]         rsp_finish_time,
   output logic [1:0]                             rsp_row_event
);

   logic [drbt_pkg::DELAY_BITS-1:0] row_delay_ff, row_delay_in;
   logic [drbt_pkg::DELAY_BITS-1:0] column_delay_ff, column_delay_in;
   logic                            csr_write;
   logic                            csr_index;
   drbt_pkg::back_status_type       status;
   logic                            queue_full;
   logic                            push_valid;
   drbt_pkg::entry_type             push_entry;
   logic                            pop_valid;
   logic                            pop_ready;
   drbt_pkg::entry_type             pop_entry;

   // The register port never inserts wait states.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // Registers sit on 4-byte steps, so bit 2 of the address picks one.
   assign csr_index = paddr[2];

   always_comb begin
      row_delay_in    = row_delay_ff;
      column_delay_in = column_delay_ff;
      if (csr_write) begin
         unique case (csr_index)
            drbt_pkg::CSR_ROW_DELAY: begin
               row_delay_in = pwdata[drbt_pkg::DELAY_BITS-1:0];
            end
            drbt_pkg::CSR_COLUMN_DELAY: begin
               column_delay_in = pwdata[drbt_pkg::DELAY_BITS-1:0];
            end
            default: begin
               row_delay_in = row_delay_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         drbt_pkg::CSR_ROW_DELAY: begin
            prdata = drbt_pkg::CSR_DATA_BITS'(row_delay_ff);
         end
         drbt_pkg::CSR_COLUMN_DELAY: begin
            prdata = drbt_pkg::CSR_DATA_BITS'(column_delay_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_delay_ff    <= drbt_pkg::ROW_DELAY_RESET;
         column_delay_ff <= drbt_pkg::COLUMN_DELAY_RESET;
      end else begin
         row_delay_ff    <= row_delay_in;
         column_delay_ff <= column_delay_in;
      end
   end

   // The front part classifies each request against the open row.
   drbt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_word_addr  (req_word_addr),
      .req_write_data (req_write_data),
      .req_issue_time (req_issue_time),
      .row_delay      (row_delay_ff),
      .column_delay   (column_delay_ff),
      .status         (status),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   // The queue lets the front keep accepting while a result waits.
   drbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // The back part owns the store and the bank's busy-until time.
   drbt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_start_time  (rsp_start_time),
      .rsp_finish_time (rsp_finish_time),
      .rsp_row_event   (rsp_row_event)
   );

   // No request may enter while the store is still being cleared.
   assert property (@(posedge clock) disable iff (reset)
      status.clear_busy |-> !req_ready)
      else $error("request accepted during the clearing pass");

   // Nothing can come out before the clearing pass has finished.
   assert property (@(posedge clock) disable iff (reset)
      status.clear_busy |-> !rsp_valid)
      else $error("result presented during the clearing pass");

   // The bank stays busy until the finish time of the result on display.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finish_time == status.busy_until))
      else $error("busy-until time differs from the presented finish time");

endmodule
